[rtl/core/hsxfp_pkg.sv]
// ----------------------------------------------------------------------------
// Header sum/XOR frame parser package
// Shared constants, types and interface structures of the frame parser.
// ----------------------------------------------------------------------------
package hsxfp_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 16;
   localparam int MAX_RESULTS         = 16;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 5;
   localparam int CNT_W  = 5;
   localparam int POS_W  = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0]        CSR_IDX_PAYLOAD_LENGTH = 1'b0;
   localparam logic [LEN_W-1:0]  LEN_RESET              = 5'd3;
   localparam logic [BYTE_W-1:0] HDR_FIRST              = 8'hAA;
   localparam logic [BYTE_W-1:0] HDR_SECOND             = 8'h55;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR2,
      PH_DATA,
      PH_SUM,
      PH_XOR
   } phase_type;

   typedef struct packed {
      logic              en;
      logic              bank;
      logic [CNT_W-1:0]  idx;
      logic [BYTE_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
   } desc_type;

   typedef struct packed {
      logic en;
      logic bank;
   } release_type;

endpackage

[rtl/core/hsxfp_front.sv]
// ----------------------------------------------------------------------------
// Frame parser front end
// Accepts received bytes, tracks the frame phase and the running checks,
// writes payload bytes into a free bank and hands good frames to the queue.
// ----------------------------------------------------------------------------
module hsxfp_front #(
   parameter int MAX_PAYLOAD = hsxfp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hsxfp_pkg::LEN_W-1:0]         payload_length,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hsxfp_pkg::BYTE_W-1:0]        req_tdata,
   output hsxfp_pkg::wr_type                   wr,
   output logic                                push,
   output hsxfp_pkg::desc_type                 push_desc,
   input  hsxfp_pkg::release_type              release_bank
);

   localparam int LIMIT = (MAX_PAYLOAD < hsxfp_pkg::MAX_RESULTS) ?
                          MAX_PAYLOAD : hsxfp_pkg::MAX_RESULTS;
   localparam int CW    = hsxfp_pkg::CNT_W;

   hsxfp_pkg::phase_type        phase_ff, phase_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [hsxfp_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [hsxfp_pkg::BYTE_W-1:0] xor_ff, xor_in;
   logic                        wbank_ff, wbank_in;
   logic [1:0]                  busy_ff, busy_in;

   logic          acc;
   logic [CW-1:0] eff_len;
   logic [CW-1:0] count_inc;
   logic [CW-1:0] n_out;
   logic          commit;

   assign req_tready = !((phase_ff == hsxfp_pkg::PH_DATA) && busy_ff[wbank_ff]);
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      eff_len = payload_length;
      if (eff_len == '0) begin
         eff_len = CW'(1);
      end
      if (int'(eff_len) > LIMIT) begin
         eff_len = CW'(LIMIT);
      end
   end

   assign count_inc = (count_ff == {CW{1'b1}}) ? count_ff : count_ff + CW'(1);
   assign n_out     = (int'(count_ff) > LIMIT) ? CW'(LIMIT) : count_ff;

   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         case (phase_ff)
            hsxfp_pkg::PH_HDR2: begin
               phase_in = (req_tdata == hsxfp_pkg::HDR_SECOND) ?
                          hsxfp_pkg::PH_DATA : hsxfp_pkg::PH_IDLE;
            end
            hsxfp_pkg::PH_DATA: begin
               phase_in = (count_inc >= eff_len) ? hsxfp_pkg::PH_SUM : hsxfp_pkg::PH_DATA;
            end
            hsxfp_pkg::PH_SUM: begin
               phase_in = (req_tdata == sum_ff) ? hsxfp_pkg::PH_XOR : hsxfp_pkg::PH_IDLE;
            end
            hsxfp_pkg::PH_XOR: begin
               phase_in = hsxfp_pkg::PH_IDLE;
            end
            default: begin
               phase_in = (req_tdata == hsxfp_pkg::HDR_FIRST) ?
                          hsxfp_pkg::PH_HDR2 : hsxfp_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      xor_in    = xor_ff;
      wr        = '0;
      commit    = 1'b0;
      if (acc) begin
         case (phase_ff)
            hsxfp_pkg::PH_DATA: begin
               wr.en    = int'(count_ff) < MAX_PAYLOAD;
               wr.bank  = wbank_ff;
               wr.idx   = count_ff;
               wr.data  = req_tdata;
               sum_in   = sum_ff + req_tdata;
               xor_in   = xor_ff ^ req_tdata;
               count_in = count_inc;
            end
            hsxfp_pkg::PH_XOR: begin
               commit = (req_tdata == xor_ff);
            end
            default: begin
            end
         endcase
         if (phase_in == hsxfp_pkg::PH_IDLE) begin
            count_in = '0;
            sum_in   = '0;
            xor_in   = '0;
         end
      end
   end

   assign push           = commit;
   assign push_desc.bank = wbank_ff;
   assign push_desc.count = n_out;
   assign wbank_in       = commit ? !wbank_ff : wbank_ff;

   always_comb begin
      busy_in = busy_ff;
      if (release_bank.en) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (commit) begin
         busy_in[wbank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hsxfp_pkg::PH_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         xor_ff   <= '0;
         wbank_ff <= 1'b0;
         busy_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         xor_ff   <= xor_in;
         wbank_ff <= wbank_in;
         busy_ff  <= busy_in;
      end
   end

   a_no_write_busy_bank: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !busy_ff[wr.bank])
      else $error("payload write landed in a bank that is still draining");

   a_commit_free_bank: assert property (@(posedge clock) disable iff (reset)
      commit |-> !busy_ff[wbank_ff])
      else $error("frame committed into a busy bank");

endmodule

[rtl/core/hsxfp_queue.sv]
// ----------------------------------------------------------------------------
// Frame descriptor queue
// Two-entry queue of committed frames between the front and back ends.
// ----------------------------------------------------------------------------
module hsxfp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hsxfp_pkg::desc_type push_desc,
   input  logic                pop,
   output logic                head_valid,
   output hsxfp_pkg::desc_type head_desc
);

   hsxfp_pkg::desc_type entry_ff [2];
   logic                rd_ptr_ff, rd_ptr_in;
   logic                wr_ptr_ff, wr_ptr_in;
   logic [1:0]          level_ff, level_in;
   logic                do_pop;

   assign head_valid = level_ff != 2'd0;
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;
   assign rd_ptr_in  = do_pop ? !rd_ptr_ff : rd_ptr_ff;
   assign wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
   assign level_in   = level_ff + {1'b0, push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         level_ff  <= level_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (level_ff != 2'd2) || do_pop)
      else $error("descriptor queue overflow");

endmodule

[rtl/core/hsxfp_back.sv]
// ----------------------------------------------------------------------------
// Frame parser back end
// Holds the two payload banks and drains committed frames as result beats
// through a two-entry output buffer.
// ----------------------------------------------------------------------------
module hsxfp_back #(
   parameter int MAX_PAYLOAD = hsxfp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hsxfp_pkg::wr_type             wr,
   input  logic                          q_valid,
   input  hsxfp_pkg::desc_type           q_desc,
   output logic                          q_pop,
   output hsxfp_pkg::release_type        release_bank,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hsxfp_pkg::BYTE_W-1:0]  rsp_byte,
   output logic [hsxfp_pkg::POS_W-1:0]   rsp_pos,
   output logic                          rsp_last
);

   localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int DEPTH = 2 << AW;
   localparam int CW    = hsxfp_pkg::CNT_W;
   localparam int BW    = hsxfp_pkg::BYTE_W;
   localparam int PW    = hsxfp_pkg::POS_W;

   logic [BW-1:0] mem [DEPTH];

   logic          active_ff, active_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic          rd_valid_ff;
   logic [BW-1:0] rd_data_ff;
   logic [PW-1:0] rd_pos_ff;
   logic          rd_last_ff;

   logic [BW-1:0] ob_data_ff [2];
   logic [PW-1:0] ob_pos_ff  [2];
   logic          ob_last_ff [2];
   logic          ob_head_ff, ob_head_in;
   logic          ob_tail_ff, ob_tail_in;
   logic [1:0]    ob_cnt_ff, ob_cnt_in;

   logic          pop;
   logic          credit;
   logic          issue;
   logic          last_issue;
   logic [2:0]    pending;

   assign pop        = rsp_tvalid && rsp_tready;
   assign pending    = {1'b0, ob_cnt_ff} + {2'b0, rd_valid_ff} - {2'b0, pop};
   assign credit     = pending < 3'd2;
   assign issue      = active_ff && credit;
   assign last_issue = (pos_ff + CW'(1)) == cnt_ff;
   assign q_pop      = !active_ff && q_valid;

   assign release_bank.en   = issue && last_issue;
   assign release_bank.bank = bank_ff;

   always_comb begin
      active_in = active_ff;
      bank_in   = bank_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      if (q_pop) begin
         active_in = 1'b1;
         bank_in   = q_desc.bank;
         pos_in    = '0;
         cnt_in    = q_desc.count;
      end else if (issue) begin
         pos_in = pos_ff + CW'(1);
         if (last_issue) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, AW'(wr.idx)}] <= wr.data;
      end
      if (issue) begin
         rd_data_ff <= mem[{bank_ff, AW'(pos_ff)}];
         rd_pos_ff  <= pos_ff[PW-1:0];
         rd_last_ff <= last_issue;
      end
   end

   assign ob_head_in = pop ? !ob_head_ff : ob_head_ff;
   assign ob_tail_in = rd_valid_ff ? !ob_tail_ff : ob_tail_ff;
   assign ob_cnt_in  = ob_cnt_ff + {1'b0, rd_valid_ff} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         ob_data_ff[ob_tail_ff] <= rd_data_ff;
         ob_pos_ff[ob_tail_ff]  <= rd_pos_ff;
         ob_last_ff[ob_tail_ff] <= rd_last_ff;
      end
   end

   assign rsp_tvalid = ob_cnt_ff != 2'd0;
   assign rsp_byte   = ob_data_ff[ob_head_ff];
   assign rsp_pos    = ob_pos_ff[ob_head_ff];
   assign rsp_last   = ob_last_ff[ob_head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         bank_ff     <= 1'b0;
         pos_ff      <= '0;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
         ob_head_ff  <= 1'b0;
         ob_tail_ff  <= 1'b0;
         ob_cnt_ff   <= '0;
      end else begin
         active_ff   <= active_in;
         bank_ff     <= bank_in;
         pos_ff      <= pos_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= issue;
         ob_head_ff  <= ob_head_in;
         ob_tail_ff  <= ob_tail_in;
         ob_cnt_ff   <= ob_cnt_in;
      end
   end

   a_buffer_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (ob_cnt_ff != 2'd2) || pop)
      else $error("output buffer overflow");

   a_release_once: assert property (@(posedge clock) disable iff (reset)
      release_bank.en |=> !active_ff || $past(q_pop))
      else $error("bank released while its frame is still draining");

endmodule

[rtl/core/header_sum_xor_frame_parser.sv]
// ----------------------------------------------------------------------------
// Header sum/XOR frame parser
// Parses 0xAA 0x55 framed payloads with sum and XOR checks.
// ----------------------------------------------------------------------------
// The parser takes one received byte per beat, one beat per cycle. A frame is
// 0xAA, 0x55, payload_length payload bytes, a wrapping sum byte and an XOR
// byte; a frame whose checks both match is sent out as one result beat per
// payload byte, with rsp_tlast on the final one, and any other frame is
// dropped without a trace. Payload goes into one of two banks of a dual-bank
// memory, so a frame drains at one beat per cycle, as long as rsp_tready holds,
// while the next one is received. The input stalls only when a payload byte
// arrives while both banks still hold frames that wait to drain. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module header_sum_xor_frame_parser #(
   parameter int MAX_PAYLOAD = hsxfp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // rx_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,   // payload_byte, byte_position
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [hsxfp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [hsxfp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [hsxfp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   logic [hsxfp_pkg::LEN_W-1:0] length_ff, length_in;
   logic                        csr_hit;

   hsxfp_pkg::wr_type           wr;
   logic                        push;
   hsxfp_pkg::desc_type         push_desc;
   logic                        q_valid;
   hsxfp_pkg::desc_type         q_desc;
   logic                        q_pop;
   hsxfp_pkg::release_type      release_bank;
   logic [hsxfp_pkg::BYTE_W-1:0] rsp_byte;
   logic [hsxfp_pkg::POS_W-1:0]  rsp_pos;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[hsxfp_pkg::CSR_ADDR_W-1:2] == hsxfp_pkg::CSR_IDX_PAYLOAD_LENGTH;
   assign length_in  = (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) ?
                       csr_pwdata[hsxfp_pkg::LEN_W-1:0] : length_ff;
   assign csr_prdata = csr_hit ?
                       {{(hsxfp_pkg::CSR_DATA_W - hsxfp_pkg::LEN_W){1'b0}}, length_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= hsxfp_pkg::LEN_RESET;
      end else begin
         length_ff <= length_in;
      end
   end

   hsxfp_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .payload_length (length_ff),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .wr             (wr),
      .push           (push),
      .push_desc      (push_desc),
      .release_bank   (release_bank)
   );

   hsxfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_desc  (q_desc)
   );

   hsxfp_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .q_valid      (q_valid),
      .q_desc       (q_desc),
      .q_pop        (q_pop),
      .release_bank (release_bank),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_byte     (rsp_byte),
      .rsp_pos      (rsp_pos),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, rsp_pos, rsp_byte};

endmodule

[bench/header_sum_xor_frame_parser_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser result checker
// Follows every accepted byte and every length write, works out the payload
// beats that each byte releases, and compares them in order with the beats
// that leave the parser.
// ----------------------------------------------------------------------------
module header_sum_xor_frame_parser_checker #(
   parameter int MAX_PAYLOAD = hsxfp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // rx_byte
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [15:0]                         rsp_tdata,   // payload_byte, byte_position
   input  logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hsxfp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hsxfp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  pending_beats
);

   localparam logic [hsxfp_pkg::CSR_ADDR_W-1:0] LENGTH_ADDR =
      hsxfp_pkg::CSR_ADDR_W'(4 * int'(hsxfp_pkg::CSR_IDX_PAYLOAD_LENGTH));

   typedef struct packed {
      logic [hsxfp_pkg::BYTE_W-1:0] payload_byte;
      logic [hsxfp_pkg::POS_W-1:0]  byte_position;
      logic                         last_of_frame;
   } payload_beat_type;

   hsxfp_pkg::phase_type          frame_phase;
   logic [hsxfp_pkg::CNT_W-1:0]   stored_count;
   logic [hsxfp_pkg::BYTE_W-1:0]  byte_sum;
   logic [hsxfp_pkg::BYTE_W-1:0]  byte_xor;
   logic [hsxfp_pkg::BYTE_W-1:0]  payload_mem [MAX_PAYLOAD];
   logic [hsxfp_pkg::LEN_W-1:0]   length_reg;
   payload_beat_type              beat_q [$];
   int                            mismatches = 0;

   initial begin
      fail_count    = 0;
      pending_beats = 0;
   end

   function automatic int frame_length();
      int n;
      n = int'(length_reg);
      if (n == 0)
         n = 1;
      if (n > MAX_PAYLOAD)
         n = MAX_PAYLOAD;
      if (n > hsxfp_pkg::MAX_RESULTS)
         n = hsxfp_pkg::MAX_RESULTS;
      return n;
   endfunction

   task automatic return_to_idle();
      frame_phase  = hsxfp_pkg::PH_IDLE;
      stored_count = '0;
      byte_sum     = '0;
      byte_xor     = '0;
   endtask

   task automatic parse_rx_byte(input logic [hsxfp_pkg::BYTE_W-1:0] rx);
      int               n;
      int               limit;
      payload_beat_type beat;
      case (frame_phase)
         hsxfp_pkg::PH_HDR2: begin
            if (rx == hsxfp_pkg::HDR_SECOND)
               frame_phase = hsxfp_pkg::PH_DATA;
            else
               return_to_idle();
         end
         hsxfp_pkg::PH_DATA: begin
            limit = frame_length();
            if (stored_count < MAX_PAYLOAD)
               payload_mem[stored_count] = rx;
            byte_sum = byte_sum + rx;
            byte_xor = byte_xor ^ rx;
            if (stored_count != '1)
               stored_count = stored_count + 1'b1;
            if (stored_count >= limit)
               frame_phase = hsxfp_pkg::PH_SUM;
         end
         hsxfp_pkg::PH_SUM: begin
            if (rx == byte_sum)
               frame_phase = hsxfp_pkg::PH_XOR;
            else
               return_to_idle();
         end
         hsxfp_pkg::PH_XOR: begin
            if (rx == byte_xor) begin
               n = int'(stored_count);
               if (n > MAX_PAYLOAD)
                  n = MAX_PAYLOAD;
               if (n > hsxfp_pkg::MAX_RESULTS)
                  n = hsxfp_pkg::MAX_RESULTS;
               for (int k = 0; k < n; k++) begin
                  beat.payload_byte  = payload_mem[k];
                  beat.byte_position = hsxfp_pkg::POS_W'(k);
                  beat.last_of_frame = (k == n - 1);
                  beat_q.push_back(beat);
               end
            end
            return_to_idle();
         end
         default: begin
            return_to_idle();
            if (rx == hsxfp_pkg::HDR_FIRST)
               frame_phase = hsxfp_pkg::PH_HDR2;
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      payload_beat_type want;
      if (reset) begin
         length_reg = hsxfp_pkg::LEN_RESET;
         return_to_idle();
         beat_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            parse_rx_byte(req_tdata);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == LENGTH_ADDR)
            length_reg = csr_pwdata[hsxfp_pkg::LEN_W-1:0];
         if (rsp_tvalid && rsp_tready) begin
            if (beat_q.size() == 0) begin
               $error("unexpected result beat: data %0h, last %0b", rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = beat_q.pop_front();
               if (rsp_tdata[hsxfp_pkg::BYTE_W-1:0] !== want.payload_byte) begin
                  $error("payload_byte: expected %0h, actual %0h",
                         want.payload_byte, rsp_tdata[hsxfp_pkg::BYTE_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[hsxfp_pkg::BYTE_W+hsxfp_pkg::POS_W-1:hsxfp_pkg::BYTE_W] !==
                   want.byte_position) begin
                  $error("byte_position: expected %0d, actual %0d", want.byte_position,
                         rsp_tdata[hsxfp_pkg::BYTE_W+hsxfp_pkg::POS_W-1:hsxfp_pkg::BYTE_W]);
                  mismatches++;
               end
               if (rsp_tlast !== want.last_of_frame) begin
                  $error("last_of_frame: expected %0b, actual %0b",
                         want.last_of_frame, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
      pending_beats <= beat_q.size();
      fail_count    <= mismatches;
   end

endmodule

[bench/header_sum_xor_frame_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds framed byte streams (good frames, broken headers, bad check bytes
// and noise) through the parser under several payload lengths and idle
// patterns, and lets the checker compare every payload beat.
// ----------------------------------------------------------------------------
module header_sum_xor_frame_parser_tb;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 12;
   localparam int TIMEOUT_NS      = 3_000_000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int ITEMS_PER_PHASE = 12;
   localparam int HOLD_CYCLES     = 160;
   localparam logic [hsxfp_pkg::CSR_ADDR_W-1:0] LENGTH_ADDR =
      hsxfp_pkg::CSR_ADDR_W'(4 * int'(hsxfp_pkg::CSR_IDX_PAYLOAD_LENGTH));

   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER,
      FLAW_SUM,
      FLAW_XOR
   } frame_flaw_type;

   typedef enum int {
      IDLE_SENDER_LIGHT,
      IDLE_SENDER_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   logic [7:0]                          req_tdata   = '0;    // rx_byte
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   logic [15:0]                         rsp_tdata;           // payload_byte, byte_position
   logic                                rsp_tlast;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [hsxfp_pkg::CSR_ADDR_W-1:0]    csr_paddr   = '0;
   logic [hsxfp_pkg::CSR_DATA_W-1:0]    csr_pwdata  = '0;
   logic [hsxfp_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                                csr_pready;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   int sent_bytes    = 0;
   int frame_len     = int'(hsxfp_pkg::LEN_RESET);
   int csr_errors    = 0;
   int checker_fails;
   int pending_beats;

   always #(CLOCK_HALF) clock = ~clock;

   header_sum_xor_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   header_sum_xor_frame_parser_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (checker_fails),
      .pending_beats (pending_beats)
   );

   // The receiver sits out a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER_LIGHT: begin
            send_idle_pct = 35;
            recv_idle_pct = 62;
         end
         IDLE_SENDER_HEAVY: begin
            send_idle_pct = 62;
            recv_idle_pct = 35;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent_bytes++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_length(input logic [hsxfp_pkg::LEN_W-1:0] len);
      logic [hsxfp_pkg::CSR_DATA_W-1:0] wdata;
      logic [hsxfp_pkg::CSR_DATA_W-1:0] rdata;
      wdata                       = $urandom;
      wdata[hsxfp_pkg::LEN_W-1:0] = len;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= LENGTH_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rdata[hsxfp_pkg::LEN_W-1:0] !== len) begin
         $error("payload_length: expected %0d, actual %0d", len,
                rdata[hsxfp_pkg::LEN_W-1:0]);
         csr_errors++;
      end
      frame_len = (len == 0) ? 1 : int'(len);
      if (frame_len > hsxfp_pkg::MAX_PAYLOAD_DEFAULT)
         frame_len = hsxfp_pkg::MAX_PAYLOAD_DEFAULT;
      if (frame_len > hsxfp_pkg::MAX_RESULTS)
         frame_len = hsxfp_pkg::MAX_RESULTS;
   endtask

   task automatic send_frame(input frame_flaw_type flaw);
      logic [7:0] body [hsxfp_pkg::MAX_PAYLOAD_DEFAULT];
      logic [7:0] sum_b;
      logic [7:0] xor_b;
      logic [7:0] bad;
      int         style;
      style = $urandom_range(7);
      sum_b = '0;
      xor_b = '0;
      for (int i = 0; i < frame_len; i++) begin
         case (style)
            0:       body[i] = 8'h00;
            1:       body[i] = 8'hFF;
            2:       body[i] = (i % 2) ? hsxfp_pkg::HDR_SECOND : hsxfp_pkg::HDR_FIRST;
            default: body[i] = 8'($urandom);
         endcase
         sum_b = sum_b + body[i];
         xor_b = xor_b ^ body[i];
      end
      send_byte(hsxfp_pkg::HDR_FIRST);
      if (flaw == FLAW_HEADER) begin
         bad = 8'($urandom);
         if (bad == hsxfp_pkg::HDR_SECOND)
            bad = ~bad;
         send_byte(bad);
      end else begin
         send_byte(hsxfp_pkg::HDR_SECOND);
         for (int i = 0; i < frame_len; i++)
            send_byte(body[i]);
         if (flaw == FLAW_SUM)
            sum_b = sum_b ^ 8'($urandom_range(1, 255));
         if (flaw == FLAW_XOR)
            xor_b = xor_b ^ 8'($urandom_range(1, 255));
         send_byte(sum_b);
         send_byte(xor_b);
      end
   endtask

   task automatic send_random_traffic(input int count);
      int target;
      int pick;
      target = sent_bytes + count;
      while (sent_bytes < target) begin
         pick = $urandom_range(99);
         if (pick < 70)
            send_frame(FLAW_NONE);
         else if (pick < 78)
            send_frame(FLAW_HEADER);
         else if (pick < 86)
            send_frame(FLAW_SUM);
         else if (pick < 94)
            send_frame(FLAW_XOR);
         else
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
   endtask

   initial begin : stimulus
      logic [7:0] directed_bytes [$];
      logic [7:0] first_b;
      logic [7:0] second_b;
      logic [hsxfp_pkg::LEN_W-1:0] lengths [$];
      directed_bytes = '{
         hsxfp_pkg::HDR_FIRST, hsxfp_pkg::HDR_SECOND, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h7F,
         hsxfp_pkg::HDR_FIRST, 8'h00,
         hsxfp_pkg::HDR_FIRST, hsxfp_pkg::HDR_FIRST, hsxfp_pkg::HDR_SECOND,
         hsxfp_pkg::HDR_FIRST, hsxfp_pkg::HDR_SECOND, 8'h01, 8'h02, 8'h03, 8'h00,
         hsxfp_pkg::HDR_FIRST, hsxfp_pkg::HDR_SECOND, 8'h10, 8'h20, 8'h30, 8'h60, 8'h01
      };
      lengths = '{5'd16, 5'd0, 5'd31, 5'd17,
                  hsxfp_pkg::LEN_W'($urandom_range(2, 15))};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(IDLE_SENDER_LIGHT);
      foreach (directed_bytes[i])
         send_byte(directed_bytes[i]);
      wait_drained();

      // Several good frames against a stopped receiver fill both banks.
      hold_left <= HOLD_CYCLES;
      repeat (4) send_frame(FLAW_NONE);
      wait_drained();
      send_random_traffic(ITEMS_PER_PHASE);
      wait_drained();

      // The length drops while a frame is in its payload.
      first_b  = 8'($urandom);
      second_b = 8'($urandom);
      send_byte(hsxfp_pkg::HDR_FIRST);
      send_byte(hsxfp_pkg::HDR_SECOND);
      send_byte(first_b);
      wait_drained();
      set_length(5'd1);
      send_byte(second_b);
      send_byte(first_b + second_b);
      send_byte(first_b ^ second_b);
      send_random_traffic(ITEMS_PER_PHASE);

      foreach (lengths[i]) begin
         wait_drained();
         set_length(lengths[i]);
         if (i < 1)
            set_idling(IDLE_SENDER_LIGHT);
         else if (i < 3)
            set_idling(IDLE_SENDER_HEAVY);
         else
            set_idling(IDLE_NONE);
         send_random_traffic(ITEMS_PER_PHASE);
      end

      wait_drained();
      if (checker_fails == 0 && csr_errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
